@@ sv/flg_pkg.sv @@
// -----------------------------------------------------------------------------
// flg_pkg: shared definitions for the stereo flanger
// Default sizes, register indexes, the configuration bundle and the fixed
// constants of the sine table generator.
// -----------------------------------------------------------------------------
package flg_pkg;

   // Default sizes.
   localparam int LINE_DEPTH       = 2048;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SAMPLE_BITS      = 24;
   localparam int QUEUE_DEPTH      = 2;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PHASE_STEP = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_DELAY  = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX_DELAY  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DEPTH      = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WET_MIX    = 3'd5;

   // Register reset values.
   localparam logic [18:0] MIN_DELAY_RESET = 19'd1229;
   localparam logic [18:0] MAX_DELAY_RESET = 19'd122880;
   localparam logic [16:0] DEPTH_RESET     = 17'd32768;
   localparam logic [16:0] WET_MIX_RESET   = 17'd32768;

   // Unity in Q1.16.
   localparam logic [16:0] UNITY_Q16 = 17'h10000;

   // Q30 constants for the sine table.
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic        enable;
      logic [31:0] phase_step;
      logic [18:0] min_delay;
      logic [18:0] max_delay;
      logic [16:0] depth;
      logic [16:0] wet_mix;
   } cfg_type;

endpackage

@@ sv/flg_queue.sv @@
// -----------------------------------------------------------------------------
// flg_queue: small job queue between front and back
// Holds classified jobs so that the front and the back can stall independently.
// -----------------------------------------------------------------------------
module flg_queue #(
   parameter int Width = 8,
   parameter int Depth = flg_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   input  logic [Width-1:0] wdata,
   output logic [Width-1:0] rdata
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] slot_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ sv/flg_front.sv @@
// -----------------------------------------------------------------------------
// flg_front: sample intake and delay computation
// Accepts a stereo pair, reads the sine LFO table, computes the clamped
// fractional delay and pushes one job into the queue.
// -----------------------------------------------------------------------------
module flg_front #(
   parameter int LineDepth  = flg_pkg::LINE_DEPTH,
   parameter int TableDepth = flg_pkg::SINE_TABLE_DEPTH,
   parameter int SampleBits = flg_pkg::SAMPLE_BITS,
   parameter int JobW       = 1 + 2 * SampleBits + $clog2(LineDepth) + 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  flg_pkg::cfg_type             cfg,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [SampleBits-1:0] req_left_in,
   input  logic signed [SampleBits-1:0] req_right_in,
   output logic                         q_push,
   input  logic                         q_full,
   output logic [JobW-1:0]              q_data
);

   localparam int AW    = $clog2(LineDepth);
   localparam int TW    = $clog2(TableDepth);
   localparam int DlyW  = AW + 8;
   localparam int CalcW = (DlyW + 1 > 22) ? DlyW + 1 : 22;
   localparam logic signed [CalcW-1:0] MaxDly = CalcW'((LineDepth - 2) * 256);

   localparam logic [1:0] FS_IDLE = 2'd0;
   localparam logic [1:0] FS_MUL1 = 2'd1;
   localparam logic [1:0] FS_MUL2 = 2'd2;
   localparam logic [1:0] FS_PUSH = 2'd3;

   typedef logic [16:0] sine_rom_type [TableDepth];

   // One table entry: (sin + 1) / 2 in Q1.16 from a Q30 quarter-wave series.
   function automatic logic [16:0] sine_entry(input int k);
      logic [63:0] x, x2, r, s, v;
      logic        neg;
      x   = (64'(k) * flg_pkg::TWO_PI_Q30) / TableDepth;
      neg = 1'b0;
      if (x >= flg_pkg::PI_Q30) begin
         neg = 1'b1;
         x   = x - flg_pkg::PI_Q30;
      end
      if (x > flg_pkg::HALF_PI_Q30) begin
         x = flg_pkg::PI_Q30 - x;
      end
      x2 = (x * x) >> 30;
      r  = flg_pkg::Q30_ONE;
      r  = flg_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd110;
      r  = flg_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd72;
      r  = flg_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd42;
      r  = flg_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd20;
      r  = flg_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd6;
      s  = (x * r) >> 30;
      if (s > flg_pkg::Q30_ONE) begin
         s = flg_pkg::Q30_ONE;
      end
      v = neg ? flg_pkg::Q30_ONE - s : flg_pkg::Q30_ONE + s;
      v = (v + 64'd16384) >> 15;
      return v[16:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < TableDepth; k++) begin
         rom[k] = sine_entry(k);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [1:0]                    state_ff, state_in;
   logic [31:0]                   phase_ff, phase_in;
   logic [16:0]                   rom_q_ff;
   logic signed [SampleBits-1:0]  left_ff, right_ff;
   logic                          bypass_ff;
   logic [32:0]                   prod_ff;
   logic signed [53:0]            scaled_ff;
   logic [16:0]                   dep;
   logic [33:0]                   prod_full;
   logic signed [19:0]            span;
   logic signed [53:0]            scaled_in;
   logic signed [CalcW-1:0]       dly_full, dly_clamp;
   logic                          accept;

   assign accept   = req_push && !req_full;
   assign req_full = (state_ff != FS_IDLE);

   // Depth above one acts as one.
   assign dep       = (cfg.depth > flg_pkg::UNITY_Q16) ? flg_pkg::UNITY_Q16 : cfg.depth;
   assign prod_full = rom_q_ff * dep;
   assign span      = $signed({1'b0, cfg.max_delay}) - $signed({1'b0, cfg.min_delay});
   assign scaled_in = $signed({1'b0, prod_ff}) * span;

   // Delay = min + floor(lfo * depth * span / 2^32), clamped to the line.
   always_comb begin
      dly_full = CalcW'($signed({1'b0, cfg.min_delay})) + CalcW'($signed(scaled_ff[53:32]));
      if (dly_full > MaxDly) begin
         dly_clamp = MaxDly;
      end else if (dly_full < 0) begin
         dly_clamp = '0;
      end else begin
         dly_clamp = dly_full;
      end
   end

   assign q_push = (state_ff == FS_PUSH);
   assign q_data = {bypass_ff, left_ff, right_ff, dly_clamp[DlyW-1:0]};

   // Sequencer: intake, two multiply steps, push.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               state_in = FS_MUL1;
               if (cfg.enable) begin
                  phase_in = phase_ff + cfg.phase_step;
               end
            end
         end
         FS_MUL1: state_in = FS_MUL2;
         FS_MUL2: state_in = FS_PUSH;
         FS_PUSH: begin
            if (!q_full) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // Table read at the current phase, and datapath registers.
   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[phase_ff[31 -: TW]];
      if (accept) begin
         left_ff   <= req_left_in;
         right_ff  <= req_right_in;
         bypass_ff <= !cfg.enable;
      end
      if (state_ff == FS_MUL1) begin
         prod_ff <= prod_full[32:0];
      end
      if (state_ff == FS_MUL2) begin
         scaled_ff <= scaled_in;
      end
   end

endmodule

@@ sv/flg_back.sv @@
// -----------------------------------------------------------------------------
// flg_back: delay lines, interpolation and mix
// Writes each non-bypass pair into the circular lines, reads the two neighbors of
// the fractional tap, interpolates, mixes dry/wet, holds it or a bypass pair as is.
// -----------------------------------------------------------------------------
module flg_back #(
   parameter int LineDepth  = flg_pkg::LINE_DEPTH,
   parameter int SampleBits = flg_pkg::SAMPLE_BITS,
   parameter int JobW       = 1 + 2 * SampleBits + $clog2(LineDepth) + 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  flg_pkg::cfg_type             cfg,
   input  logic                         q_empty,
   output logic                         q_pop,
   input  logic [JobW-1:0]              q_data,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [SampleBits-1:0] rsp_left_out,
   output logic signed [SampleBits-1:0] rsp_right_out
);

   localparam int AW   = $clog2(LineDepth);
   localparam int DlyW = AW + 8;
   localparam int SB   = SampleBits;

   localparam logic [1:0] BS_IDLE   = 2'd0;
   localparam logic [1:0] BS_INTERP = 2'd1;
   localparam logic [1:0] BS_MIX    = 2'd2;
   localparam logic [1:0] BS_SUM    = 2'd3;

   logic [SB-1:0] left_mem  [LineDepth];
   logic [SB-1:0] right_mem [LineDepth];

   logic [1:0]            state_ff, state_in;
   logic [AW-1:0]         wp_ff;
   logic                  wrapped_ff;
   logic                  out_valid_ff, out_valid_in;
   logic signed [SB-1:0]  out_left_ff, out_right_ff;

   logic                  h_bypass;
   logic signed [SB-1:0]  h_left, h_right;
   logic [DlyW-1:0]       h_dly, pos;
   logic [AW-1:0]         idx0, idx1;
   logic                  out_free, start, load_bypass, load_sum;

   logic [SB-1:0]         rl0_ff, rl1_ff, rr0_ff, rr1_ff;
   logic [7:0]            frac_ff;
   logic                  hit0_ff, hit1_ff, vld0_ff, vld1_ff;
   logic signed [SB-1:0]  cur_l_ff, cur_r_ff, wet_l_ff, wet_r_ff;
   logic signed [SB+17:0] pd_l_ff, pw_l_ff, pd_r_ff, pw_r_ff;

   logic signed [SB-1:0]  a_l, b_l, a_r, b_r;
   logic signed [SB+10:0] int_l, int_r;
   logic signed [9:0]     w_a, w_b;
   logic [16:0]           m, m_dry;
   logic signed [SB+18:0] sum_l, sum_r;
   logic signed [SB-1:0]  sat_l, sat_r;

   // Job fields.
   assign {h_bypass, h_left, h_right, h_dly} = q_data;

   // Read position: write position minus the delay, modulo the line length.
   assign pos  = {wp_ff, 8'd0} - h_dly;
   assign idx0 = pos[DlyW-1:8];
   assign idx1 = idx0 + 1'b1;

   assign out_free    = !out_valid_ff || rsp_pop;
   assign start       = (state_ff == BS_IDLE) && !q_empty && !h_bypass;
   assign load_bypass = (state_ff == BS_IDLE) && !q_empty && h_bypass && out_free;
   assign load_sum    = (state_ff == BS_SUM) && out_free;
   assign q_pop       = start || load_bypass;

   // Delay line write, dual read of both neighbors.
   always_ff @(posedge clock) begin
      if (start) begin
         left_mem[wp_ff]  <= h_left;
         right_mem[wp_ff] <= h_right;
         rl0_ff           <= left_mem[idx0];
         rl1_ff           <= left_mem[idx1];
         rr0_ff           <= right_mem[idx0];
         rr1_ff           <= right_mem[idx1];
      end
   end

   // Entries not yet written read as zero; the entry written now reads the new pair.
   always_ff @(posedge clock) begin
      if (start) begin
         frac_ff  <= pos[7:0];
         hit0_ff  <= (idx0 == wp_ff);
         hit1_ff  <= (idx1 == wp_ff);
         vld0_ff  <= wrapped_ff || (idx0 < wp_ff);
         vld1_ff  <= wrapped_ff || (idx1 < wp_ff);
         cur_l_ff <= h_left;
         cur_r_ff <= h_right;
      end
   end

   always_comb begin
      a_l = hit0_ff ? cur_l_ff : (vld0_ff ? $signed(rl0_ff) : '0);
      a_r = hit0_ff ? cur_r_ff : (vld0_ff ? $signed(rr0_ff) : '0);
      b_l = hit1_ff ? cur_l_ff : (vld1_ff ? $signed(rl1_ff) : '0);
      b_r = hit1_ff ? cur_r_ff : (vld1_ff ? $signed(rr1_ff) : '0);
   end

   // Linear interpolation between the two neighbors.
   assign w_a   = $signed(10'd256 - {2'b00, frac_ff});
   assign w_b   = $signed({2'b00, frac_ff});
   assign int_l = a_l * w_a + b_l * w_b;
   assign int_r = a_r * w_a + b_r * w_b;

   // Mix weights; a mix above one acts as one.
   assign m     = (cfg.wet_mix > flg_pkg::UNITY_Q16) ? flg_pkg::UNITY_Q16 : cfg.wet_mix;
   assign m_dry = flg_pkg::UNITY_Q16 - m;

   always_ff @(posedge clock) begin
      if (state_ff == BS_INTERP) begin
         wet_l_ff <= int_l[SB+7:8];
         wet_r_ff <= int_r[SB+7:8];
      end
      if (state_ff == BS_MIX) begin
         pd_l_ff <= cur_l_ff * $signed({1'b0, m_dry});
         pw_l_ff <= wet_l_ff * $signed({1'b0, m});
         pd_r_ff <= cur_r_ff * $signed({1'b0, m_dry});
         pw_r_ff <= wet_r_ff * $signed({1'b0, m});
      end
   end

   // Sum, floor by 2^16 and saturate to the sample range.
   assign sum_l = (SB+19)'(pd_l_ff) + (SB+19)'(pw_l_ff);
   assign sum_r = (SB+19)'(pd_r_ff) + (SB+19)'(pw_r_ff);

   always_comb begin
      if ((sum_l[SB+18:SB+15] == 4'b0000) || (sum_l[SB+18:SB+15] == 4'b1111)) begin
         sat_l = sum_l[SB+15:16];
      end else begin
         sat_l = sum_l[SB+18] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end
      if ((sum_r[SB+18:SB+15] == 4'b0000) || (sum_r[SB+18:SB+15] == 4'b1111)) begin
         sat_r = sum_r[SB+15:16];
      end else begin
         sat_r = sum_r[SB+18] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_IDLE: begin
            if (start) begin
               state_in = BS_INTERP;
            end
         end
         BS_INTERP: state_in = BS_MIX;
         BS_MIX:    state_in = BS_SUM;
         BS_SUM: begin
            if (out_free) begin
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_pop;
      if (load_bypass || load_sum) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (start) begin
            wp_ff <= wp_ff + 1'b1;
            if (wp_ff == {AW{1'b1}}) begin
               wrapped_ff <= 1'b1;
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load_bypass) begin
         out_left_ff  <= h_left;
         out_right_ff <= h_right;
      end else if (load_sum) begin
         out_left_ff  <= sat_l;
         out_right_ff <= sat_r;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_left_out  = out_left_ff;
   assign rsp_right_out = out_right_ff;

endmodule

@@ sv/stereo_flanger.sv @@
// -----------------------------------------------------------------------------
// stereo_flanger: stereo flanger with sine LFO and interpolated delay lines
// Top level: configuration registers, front, job queue and back.
// -----------------------------------------------------------------------------
// Usage:
// Input pairs enter through req_push / req_full; a transaction completes on a
// clock edge with req_push high and req_full low. Results leave through
// rsp_empty / rsp_pop in the same order; the oldest result sits on the rsp_
// ports while rsp_empty is low and is taken when rsp_pop is high.
// The front holds one pair through the table read, two multiply steps and the
// queue push, and takes no new pair before the push. The back also works on
// one pair at a time (line write with dual read, interpolate, mix, sum); a pair
// taken while disabled skips these and goes straight to the output register.
// A result waiting in the output register does not stop intake: the job queue
// and the back keep working until the queue fills, then req_full stays high.
// Reset clears the LFO phase, the write position and the line fill mark;
// line entries never written read as zero, so no clearing pass is needed.
// Configuration is written through csr_write / csr_addr / csr_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// -----------------------------------------------------------------------------
module stereo_flanger #(
   parameter int LineDepth      = flg_pkg::LINE_DEPTH,
   parameter int SineTableDepth = flg_pkg::SINE_TABLE_DEPTH,
   parameter int SampleBits     = flg_pkg::SAMPLE_BITS,
   parameter int QueueDepth     = flg_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [SampleBits-1:0]        req_left_in,
   input  logic signed [SampleBits-1:0]        req_right_in,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [SampleBits-1:0]        rsp_left_out,
   output logic signed [SampleBits-1:0]        rsp_right_out,
   input  logic                                csr_write,
   input  logic [flg_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [flg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int JobW = 1 + 2 * SampleBits + $clog2(LineDepth) + 8;

   flg_pkg::cfg_type cfg_ff;
   logic             q_push, q_full, q_pop, q_empty;
   logic [JobW-1:0]  q_wdata, q_rdata;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable     <= 1'b0;
         cfg_ff.phase_step <= '0;
         cfg_ff.min_delay  <= flg_pkg::MIN_DELAY_RESET;
         cfg_ff.max_delay  <= flg_pkg::MAX_DELAY_RESET;
         cfg_ff.depth      <= flg_pkg::DEPTH_RESET;
         cfg_ff.wet_mix    <= flg_pkg::WET_MIX_RESET;
      end else if (csr_write) begin
         case (csr_addr)
            flg_pkg::CSR_ENABLE:     cfg_ff.enable     <= csr_wdata[0];
            flg_pkg::CSR_PHASE_STEP: cfg_ff.phase_step <= csr_wdata;
            flg_pkg::CSR_MIN_DELAY:  cfg_ff.min_delay  <= csr_wdata[18:0];
            flg_pkg::CSR_MAX_DELAY:  cfg_ff.max_delay  <= csr_wdata[18:0];
            flg_pkg::CSR_DEPTH:      cfg_ff.depth      <= csr_wdata[16:0];
            flg_pkg::CSR_WET_MIX:    cfg_ff.wet_mix    <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Front: intake and delay computation.
   flg_front #(
      .LineDepth  (LineDepth),
      .TableDepth (SineTableDepth),
      .SampleBits (SampleBits),
      .JobW       (JobW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_left_in  (req_left_in),
      .req_right_in (req_right_in),
      .q_push       (q_push),
      .q_full       (q_full),
      .q_data       (q_wdata)
   );

   // Job queue.
   flg_queue #(
      .Width (JobW),
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .wdata (q_wdata),
      .rdata (q_rdata)
   );

   // Back: delay lines and mix.
   flg_back #(
      .LineDepth  (LineDepth),
      .SampleBits (SampleBits),
      .JobW       (JobW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_data        (q_rdata),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule

@@ sv/flg_checker.sv @@
// -----------------------------------------------------------------------------
// flg_checker: port-level checks for the stereo flanger
// Watches the top-level ports over time; attached to the top level by bind.
// -----------------------------------------------------------------------------
module flg_checker #(
   parameter int SampleBits = flg_pkg::SAMPLE_BITS
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_push,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [SampleBits-1:0] rsp_left_out,
   input logic [SampleBits-1:0] rsp_right_out
);

   // Reset leaves no result behind.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // Intake is open right after reset.
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("intake closed after reset");

   // After each transaction the front's state register closes intake.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |=> req_full)
      else $error("intake open right after a transaction");

   // A waiting result holds its value.
   a_result_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_left_out)
      && $stable(rsp_right_out))
      else $error("waiting result changed");

endmodule

bind stereo_flanger flg_checker #(
   .SampleBits (SampleBits)
) u_flg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_push      (req_push),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out)
);
